// ----- hdl/qte_pkg.sv -----
// Package: shared types, constants and the CORDIC angle table for quaternion to Euler conversion.
package qte_pkg;

	localparam int Q_W              = 16;
	localparam int ANG_W            = 16;
	localparam int THR_W            = 15;
	localparam int OPW              = 34;
	localparam int CW               = 46;
	localparam int ZW               = 26;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [THR_W-1:0] THR_RESET = 15'd32702;

	localparam logic [1:0] PC_REGULAR = 2'd0;
	localparam logic [1:0] PC_NORTH   = 2'd1;
	localparam logic [1:0] PC_SOUTH   = 2'd2;

	localparam logic signed [ANG_W-1:0] ATT_NORTH = 16'sd5760;
	localparam logic signed [ANG_W-1:0] ATT_SOUTH = -16'sd5760;

	localparam logic signed [ZW-1:0] Z_PLUS90  = 26'sd5898240;
	localparam logic signed [ZW-1:0] Z_MINUS90 = -26'sd5898240;

	// word handed from the front end to the back end
	typedef struct packed {
		logic [63:0]            d;
		logic signed [OPW-1:0]  hy;
		logic signed [OPW-1:0]  hx;
		logic signed [OPW-1:0]  by;
		logic signed [OPW-1:0]  bx;
		logic signed [32:0]     test;
		logic [1:0]             pcase;
		logic                   zero;
	} item_t;

	// square-root stage contents
	typedef struct packed {
		logic [63:0]            rem;
		logic [31:0]            root;
		logic signed [OPW-1:0]  hy;
		logic signed [OPW-1:0]  hx;
		logic signed [OPW-1:0]  by;
		logic signed [OPW-1:0]  bx;
		logic signed [32:0]     test;
		logic [1:0]             pcase;
		logic                   zero;
	} sq_t;

	typedef struct packed {
		logic [1:0] pcase;
		logic       zero;
	} side_t;

	// round(atan(2^-i) deg * 65536)
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:  r = 26'sd2949120;
			1:  r = 26'sd1740967;
			2:  r = 26'sd919879;
			3:  r = 26'sd466945;
			4:  r = 26'sd234379;
			5:  r = 26'sd117304;
			6:  r = 26'sd58666;
			7:  r = 26'sd29335;
			8:  r = 26'sd14668;
			9:  r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/qte_if.sv -----
// Interfaces: quaternion input channel and Euler angle output channel.
interface qte_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [qte_pkg::Q_W-1:0]       quat_w;
	logic signed [qte_pkg::Q_W-1:0]       quat_x;
	logic signed [qte_pkg::Q_W-1:0]       quat_y;
	logic signed [qte_pkg::Q_W-1:0]       quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [qte_pkg::ANG_W-1:0]     bank_angle;
	logic signed [qte_pkg::ANG_W-1:0]     heading_angle;
	logic signed [qte_pkg::ANG_W-1:0]     attitude_angle;
	logic [1:0]                           pole_case;
	logic                                 zero_norm;
	modport source (output valid, bank_angle, heading_angle, attitude_angle, pole_case,
		zero_norm, input ready);
	modport sink (input valid, bank_angle, heading_angle, attitude_angle, pole_case,
		zero_norm, output ready);
endinterface

// ----- hdl/quaternion_to_euler_angles_top.sv -----
// Path is front, queue, input register, 32 root stages, CORDIC lanes, output register.
// Throughput: one quaternion per clock; the front pipeline, the two-entry queue and
//   the back pipeline each stall on their own, and the queue decouples the stalls.
// The back pipeline holds as a whole while the output register waits for ready.
// Reset (arst_n low, asynchronous): all valid bits cleared, queue emptied,
//   pole_threshold back to 32702 (0.499). No clearing pass; ready right after reset.
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [qte_pkg::THR_W-1:0]    cfg_wr_data,
	qte_in_if.sink                       quat_in,
	qte_out_if.source                    euler_out
);
	// gimbal-lock threshold, unsigned 15-bit fraction with LSB 2^-16 (Q0.16 scale)
	logic [qte_pkg::THR_W-1:0] thr_q;

	// front -> queue
	logic           f_push;
	logic           f_ready;
	qte_pkg::item_t f_item;

	// queue -> back
	logic           b_valid;
	logic           b_pop;
	qte_pkg::item_t b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qte_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// squares, norm, pole test, pole classification, root radicand
	qte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.quat_in    (quat_in),
		.push       (f_push),
		.fifo_ready (f_ready),
		.item       (f_item)
	);

	// short queue so a stalled back end does not freeze the front combinationally
	qte_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wr_item  (f_item),
		.wr_ready (f_ready),
		.pop      (b_pop),
		.rd_valid (b_valid),
		.rd_item  (b_item)
	);

	// square root for the attitude cosine, then three atan2 lanes and rounding
	qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_item    (b_item),
		.pop       (b_pop),
		.euler_out (euler_out)
	);

endmodule

// ----- hdl/qte_front.sv -----
// Front end: products, sums, pole classification and the radicand for the attitude root.
module qte_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [qte_pkg::THR_W-1:0]     thr,
	qte_in_if.sink                        quat_in,
	output logic                          push,
	input  logic                          fifo_ready,
	output qte_pkg::item_t                item
);
	localparam int OPW = qte_pkg::OPW;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: products
	logic signed [31:0] pww_s1, pxx_s1, pyy_s1, pzz_s1;
	logic signed [31:0] pxy_s1, pzw_s1, pyw_s1, pxz_s1, pxw_s1, pyz_s1;
	logic signed [15:0] qw_s1, qx_s1;

	// stage 2: sums
	logic [32:0]            norm_s2;
	logic signed [32:0]     test_s2;
	logic signed [OPW-1:0]  hy_s2, hx_s2, by_s2, bx_s2, hm_s2, hp_s2;
	logic signed [15:0]     qw_s2, qx_s2;

	// stage 3: threshold product and radicand partial products
	logic [47:0]            lim_s3;
	logic [48:0]            plo_s3;
	logic [49:0]            phi_s3;
	logic [32:0]            norm_s3;
	logic signed [32:0]     test_s3;
	logic signed [OPW-1:0]  hy_s3, hx_s3, by_s3, bx_s3;
	logic signed [15:0]     qw_s3, qx_s3;

	qte_pkg::item_t item_s4;

	logic signed [34:0]     n_sum;
	logic signed [32:0]     t_sum;
	logic [31:0]            half;
	logic signed [48:0]     ts;
	logic signed [48:0]     lim_sx;
	logic                   north, south, zero;
	logic [65:0]            d_full;

	assign en            = !v_s4 || fifo_ready;
	assign quat_in.ready = en;
	assign push          = v_s4;
	assign item          = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= quat_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pww_s1 <= quat_in.quat_w * quat_in.quat_w;
			pxx_s1 <= quat_in.quat_x * quat_in.quat_x;
			pyy_s1 <= quat_in.quat_y * quat_in.quat_y;
			pzz_s1 <= quat_in.quat_z * quat_in.quat_z;
			pxy_s1 <= quat_in.quat_x * quat_in.quat_y;
			pzw_s1 <= quat_in.quat_z * quat_in.quat_w;
			pyw_s1 <= quat_in.quat_y * quat_in.quat_w;
			pxz_s1 <= quat_in.quat_x * quat_in.quat_z;
			pxw_s1 <= quat_in.quat_x * quat_in.quat_w;
			pyz_s1 <= quat_in.quat_y * quat_in.quat_z;
			qw_s1  <= quat_in.quat_w;
			qx_s1  <= quat_in.quat_x;
		end
	end

	always_comb begin
		n_sum = 35'(pww_s1) + 35'(pxx_s1) + 35'(pyy_s1) + 35'(pzz_s1);
		t_sum = 33'(pxy_s1) + 33'(pzw_s1);
		half  = n_sum[32:1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2 <= n_sum[32:0];
			test_s2 <= t_sum;
			hy_s2   <= (34'(pyw_s1) - 34'(pxz_s1)) <<< 1;
			hx_s2   <= 34'(pxx_s1) - 34'(pyy_s1) - 34'(pzz_s1) + 34'(pww_s1);
			by_s2   <= (34'(pxw_s1) - 34'(pyz_s1)) <<< 1;
			bx_s2   <= 34'(pyy_s1) - 34'(pxx_s1) - 34'(pzz_s1) + 34'(pww_s1);
			hm_s2   <= 34'(signed'({2'b00, half})) - 34'(t_sum);
			hp_s2   <= 34'(signed'({2'b00, half})) + 34'(t_sum);
			qw_s2   <= qw_s1;
			qx_s2   <= qx_s1;
		end
	end

	// only meaningful on the regular path, where both factors are non-negative
	always_ff @(posedge clk) begin
		if (en) begin
			lim_s3  <= 48'(thr) * 48'(norm_s2);
			plo_s3  <= 49'(hm_s2[32:0]) * 49'(hp_s2[15:0]);
			phi_s3  <= 50'(hm_s2[32:0]) * 50'(hp_s2[32:16]);
			norm_s3 <= norm_s2;
			test_s3 <= test_s2;
			hy_s3   <= hy_s2;
			hx_s3   <= hx_s2;
			by_s3   <= by_s2;
			bx_s3   <= bx_s2;
			qw_s3   <= qw_s2;
			qx_s3   <= qx_s2;
		end
	end

	always_comb begin
		ts     = {test_s3, 16'b0};
		lim_sx = signed'({1'b0, lim_s3});
		zero   = (norm_s3 == 33'd0);
		north  = !zero && (ts > lim_sx);
		south  = !zero && !north && (ts < -lim_sx);
		d_full = 66'(plo_s3) + (66'(phi_s3) << 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4.d    <= d_full[63:0];
			item_s4.by   <= by_s3;
			item_s4.bx   <= bx_s3;
			item_s4.test <= test_s3;
			item_s4.zero <= zero;
			if (north || south) begin
				item_s4.hy <= 34'(qx_s3);
				item_s4.hx <= 34'(qw_s3);
			end else begin
				item_s4.hy <= hy_s3;
				item_s4.hx <= hx_s3;
			end
			priority if (north) begin
				item_s4.pcase <= qte_pkg::PC_NORTH;
			end else if (south) begin
				item_s4.pcase <= qte_pkg::PC_SOUTH;
			end else begin
				item_s4.pcase <= qte_pkg::PC_REGULAR;
			end
		end
	end

endmodule

// ----- hdl/qte_fifo.sv -----
// Two-entry queue between the front end and the back end.
module qte_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qte_pkg::item_t  wr_item,
	output logic            wr_ready,
	input  logic            pop,
	output logic            rd_valid,
	output qte_pkg::item_t  rd_item
);
	qte_pkg::item_t mem_q [0:1];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ----- hdl/qte_cordic.sv -----
// Pipelined vectoring CORDIC lane: normalize, quadrant fold, one stage per iteration.
module qte_cordic #(
	parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [qte_pkg::OPW-1:0]     y_in,
	input  logic signed [qte_pkg::OPW-1:0]     x_in,
	output logic signed [qte_pkg::ZW-1:0]      angle
);
	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;

	logic signed [63:0] sx, sy;
	logic [63:0]        ax, ay, m;

	logic signed [CW-1:0] nx_s1, ny_s1;
	logic                 nz_s1;

	logic signed [CW-1:0] cx_s [0:STEPS];
	logic signed [CW-1:0] cy_s [0:STEPS];
	logic signed [ZW-1:0] cz_s [0:STEPS];
	logic                 czr_s [0:STEPS];

	// scale up until the larger magnitude reaches 2^40
	always_comb begin
		sx = 64'(x_in);
		sy = 64'(y_in);
		ax = (x_in < 0) ? 64'(-sx) : 64'(sx);
		ay = (y_in < 0) ? 64'(-sy) : 64'(sy);
		m  = ax | ay;
		for (int j = 0; j < 6; j++) begin
			if ((m >> (41 - (32 >> j))) == 64'd0) begin
				m  = m << (32 >> j);
				sx = sx <<< (32 >> j);
				sy = sy <<< (32 >> j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= CW'(sx);
			ny_s1 <= CW'(sy);
			nz_s1 <= (x_in == '0) && (y_in == '0);
		end
	end

	// fold left half-plane by +-90 degrees
	always_ff @(posedge clk) begin
		if (en) begin
			czr_s[0] <= nz_s1;
			if (nx_s1 < 0) begin
				if (ny_s1 >= 0) begin
					cx_s[0] <= ny_s1;
					cy_s[0] <= -nx_s1;
					cz_s[0] <= qte_pkg::Z_PLUS90;
				end else begin
					cx_s[0] <= -ny_s1;
					cy_s[0] <= nx_s1;
					cz_s[0] <= qte_pkg::Z_MINUS90;
				end
			end else begin
				cx_s[0] <= nx_s1;
				cy_s[0] <= ny_s1;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				czr_s[i+1] <= czr_s[i];
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + qte_pkg::atan_entry(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - qte_pkg::atan_entry(i);
				end
			end
		end
	end

	assign angle = czr_s[STEPS] ? '0 : cz_s[STEPS];

endmodule

// ----- hdl/qte_back.sv -----
// Back end: bit-per-stage square root, three CORDIC lanes, rounding and output register.
module qte_back #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  qte_pkg::item_t  q_item,
	output logic            pop,
	qte_out_if.source       euler_out
);
	localparam int OPW = qte_pkg::OPW;
	localparam int ZW  = qte_pkg::ZW;
	localparam int LAT = CORDIC_STEPS + 2;
	localparam int NV  = 33 + LAT;

	logic en;
	logic vld_q [0:NV-1];
	logic out_vld_q;

	qte_pkg::sq_t   st_s [0:32];
	qte_pkg::side_t sd_s [0:LAT-1];

	logic signed [ZW-1:0]  head_a, bank_a, att_a;
	logic signed [OPW-1:0] att_y, att_x;
	logic signed [ZW+1:0]  head2;
	logic signed [ZW+1:0]  hr, br, ar;

	logic signed [qte_pkg::ANG_W-1:0] bank_q, head_q, att_q;
	logic [1:0]                       pcase_q;
	logic                             zero_q;

	assign en  = !out_vld_q || euler_out.ready;
	assign pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= q_valid;
			for (int k = 1; k < NV; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_vld_q <= vld_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].rem   <= q_item.d;
			st_s[0].root  <= '0;
			st_s[0].hy    <= q_item.hy;
			st_s[0].hx    <= q_item.hx;
			st_s[0].by    <= q_item.by;
			st_s[0].bx    <= q_item.bx;
			st_s[0].test  <= q_item.test;
			st_s[0].pcase <= q_item.pcase;
			st_s[0].zero  <= q_item.zero;
		end
	end

	// integer square root, one result bit per stage, MSB first
	for (genvar k = 1; k <= 32; k++) begin : g_sqrt
		localparam int B = 32 - k;
		logic [65:0]  cand;
		qte_pkg::sq_t nxt;
		assign cand = (66'(st_s[k-1].root) << (B + 1)) + (66'd1 << (2 * B));
		always_comb begin
			nxt = st_s[k-1];
			if (66'(st_s[k-1].rem) >= cand) begin
				nxt.rem  = st_s[k-1].rem - cand[63:0];
				nxt.root = st_s[k-1].root | (32'd1 << B);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign att_y = OPW'(st_s[32].test);
	assign att_x = OPW'(st_s[32].root);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_head (
		.clk   (clk),
		.en    (en),
		.y_in  (st_s[32].hy),
		.x_in  (st_s[32].hx),
		.angle (head_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_bank (
		.clk   (clk),
		.en    (en),
		.y_in  (st_s[32].by),
		.x_in  (st_s[32].bx),
		.angle (bank_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_att (
		.clk   (clk),
		.en    (en),
		.y_in  (att_y),
		.x_in  (att_x),
		.angle (att_a)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0].pcase <= st_s[32].pcase;
			sd_s[0].zero  <= st_s[32].zero;
			for (int k = 1; k < LAT; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	always_comb begin
		unique case (sd_s[LAT-1].pcase)
			qte_pkg::PC_NORTH: head2 = (ZW+2)'(head_a) <<< 1;
			qte_pkg::PC_SOUTH: head2 = -((ZW+2)'(head_a) <<< 1);
			default:           head2 = (ZW+2)'(head_a);
		endcase
		hr = (head2 + 28'sd512) >>> 10;
		br = ((ZW+2)'(bank_a) + 28'sd512) >>> 10;
		ar = ((ZW+2)'(att_a) + 28'sd512) >>> 10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcase_q <= sd_s[LAT-1].pcase;
			zero_q  <= sd_s[LAT-1].zero;
			if (sd_s[LAT-1].zero) begin
				head_q <= '0;
				bank_q <= '0;
				att_q  <= '0;
			end else begin
				head_q <= hr[15:0];
				unique case (sd_s[LAT-1].pcase)
					qte_pkg::PC_NORTH: begin
						bank_q <= '0;
						att_q  <= qte_pkg::ATT_NORTH;
					end
					qte_pkg::PC_SOUTH: begin
						bank_q <= '0;
						att_q  <= qte_pkg::ATT_SOUTH;
					end
					default: begin
						bank_q <= br[15:0];
						att_q  <= ar[15:0];
					end
				endcase
			end
		end
	end

	assign euler_out.valid          = out_vld_q;
	assign euler_out.bank_angle     = bank_q;
	assign euler_out.heading_angle  = head_q;
	assign euler_out.attitude_angle = att_q;
	assign euler_out.pole_case      = pcase_q;
	assign euler_out.zero_norm      = zero_q;

endmodule
